### rtl/cxpc_pkg.sv
// Shared types and constants for the chained XOR packet cipher.
package cxpc_pkg;

  // Opcodes of an input word
  localparam logic [1:0] OP_SEED = 2'd0;
  localparam logic [1:0] OP_ENC  = 2'd1;
  localparam logic [1:0] OP_DEC  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_NOKEY = 2'd2;

  // Key schedule constants
  localparam logic [31:0] SEED_XOR = 32'h9C30D539;
  localparam logic [31:0] KEY_HIGH = 32'h930FD7E2;
  localparam logic [31:0] HIGH_XOR = 32'h7C72E993;
  localparam logic [31:0] KEY_STEP = 32'h287EFFC3;

  // Result group and output queue sizing
  localparam int GRP_MAX = 4;
  localparam int GRP_CW  = 3;
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = 3;
  localparam int Q_CW    = 4;

  // One accepted input word
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic [31:0] seed;
    logic        last_byte;
  } item_t;

  // One result word
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } res_t;

  // All result words caused by one input word
  typedef struct packed {
    logic [GRP_CW-1:0]      cnt;
    res_t [GRP_MAX-1:0]     res;
  } grp_t;

  // Output queue status toward the front end
  typedef struct packed {
    logic            room;
    logic [Q_CW-1:0] count;
  } qstat_t;

endpackage

### rtl/cxpc_core.sv
// Cipher state and single-pass transform of one input word into a result group.
module cxpc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  cxpc_pkg::item_t      item,
  output cxpc_pkg::grp_t       grp
);

  localparam int GRP_CW  = cxpc_pkg::GRP_CW;
  localparam int GRP_MAX = cxpc_pkg::GRP_MAX;

  logic [63:0] enc_key_r, enc_key_nxt;
  logic [63:0] dec_key_r, dec_key_nxt;
  logic        key_vld_r, key_vld_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        past_head_r, past_head_nxt;
  logic [7:0]  chain_r, chain_nxt;
  logic [7:0]  head_r [3];
  logic [7:0]  head_nxt [3];
  logic [31:0] plain_r, plain_nxt;

  function automatic logic [7:0] key_byte(input logic [63:0] k, input logic [2:0] i);
    key_byte = k[{i, 3'b000} +: 8];
  endfunction

  // Key advance at packet end: low word is XORed with the plaintext head,
  // upper word is bumped as a big-endian value
  function automatic logic [63:0] next_key(input logic [63:0] k, input logic [31:0] ph);
    logic [31:0] be;
    logic [31:0] sum;
    be  = {k[39:32], k[47:40], k[55:48], k[63:56]};
    sum = be + cxpc_pkg::KEY_STEP;
    next_key = {sum[7:0], sum[15:8], sum[23:16], sum[31:24], k[31:0] ^ ph};
  endfunction

  logic        enc;
  logic [63:0] key;
  logic [1:0]  hp;
  logic [31:0] sr, w0, w1;
  logic [7:0]  b, h0, h1, h2, h3;
  logic [7:0]  c0, c1, c2, c3, r0, r1, r2, r3, rb;
  logic        do_upd;

  always_comb begin
    enc           = (item.opcode == cxpc_pkg::OP_ENC);
    key           = enc ? enc_key_r : dec_key_r;
    b             = item.data_byte;
    hp            = pos_r[1:0];
    enc_key_nxt   = enc_key_r;
    dec_key_nxt   = dec_key_r;
    key_vld_nxt   = key_vld_r;
    pos_nxt       = pos_r;
    past_head_nxt = past_head_r;
    chain_nxt     = chain_r;
    plain_nxt     = plain_r;
    for (int i = 0; i < 3; i++) begin
      head_nxt[i] = head_r[i];
    end
    grp    = '0;
    do_upd = 1'b0;

    // seed derivation
    sr = item.seed ^ cxpc_pkg::SEED_XOR;
    w0 = {sr[12:0], sr[31:13]};
    w1 = w0 ^ cxpc_pkg::KEY_HIGH ^ cxpc_pkg::HIGH_XOR;

    // body byte
    rb = b ^ key_byte(key, pos_r) ^ chain_r;

    // head fix-up, both directions
    h0 = head_r[0];
    h1 = head_r[1];
    h2 = head_r[2];
    h3 = b;
    if (enc) begin
      c0 = h0 ^ key_byte(key, 3'd0);
      c1 = h1 ^ key_byte(key, 3'd1) ^ c0;
      c2 = h2 ^ key_byte(key, 3'd2) ^ c1;
      c3 = h3 ^ key_byte(key, 3'd3) ^ c2;
      r3 = c3 ^ key_byte(key, 3'd2);
      r2 = c2 ^ key_byte(key, 3'd3) ^ r3;
      r1 = c1 ^ key_byte(key, 3'd4) ^ r2;
      r0 = c0 ^ key_byte(key, 3'd5) ^ r1;
    end else begin
      c3 = h3 ^ key_byte(key, 3'd2);
      c2 = h2 ^ key_byte(key, 3'd3) ^ h3;
      c1 = h1 ^ key_byte(key, 3'd4) ^ h2;
      c0 = h0 ^ key_byte(key, 3'd5) ^ h1;
      r0 = c0 ^ key_byte(key, 3'd0);
      r1 = c1 ^ key_byte(key, 3'd1) ^ c0;
      r2 = c2 ^ key_byte(key, 3'd2) ^ c1;
      r3 = c3 ^ key_byte(key, 3'd3) ^ c2;
    end

    if (fire) begin
      case (item.opcode)
        cxpc_pkg::OP_SEED: begin
          enc_key_nxt   = {w1, w0};
          dec_key_nxt   = {w1, w0};
          key_vld_nxt   = 1'b1;
          pos_nxt       = '0;
          past_head_nxt = 1'b0;
          chain_nxt     = '0;
        end
        cxpc_pkg::OP_ENC, cxpc_pkg::OP_DEC: begin
          if (!key_vld_r) begin
            // no key yet: pass through
            grp.cnt           = GRP_CW'(1);
            grp.res[0].data   = b;
            grp.res[0].last   = item.last_byte;
            grp.res[0].status = cxpc_pkg::STAT_NOKEY;
          end else if (past_head_r) begin
            grp.cnt           = GRP_CW'(1);
            grp.res[0].data   = rb;
            grp.res[0].last   = item.last_byte;
            grp.res[0].status = cxpc_pkg::STAT_OK;
            chain_nxt         = enc ? rb : b;
            pos_nxt           = pos_r + 3'd1;
            do_upd            = item.last_byte;
          end else if (hp != 2'd3) begin
            head_nxt[hp] = b;
            if (item.last_byte) begin
              // short packet: flush buffered bytes unchanged
              for (int i = 0; i < 3; i++) begin
                if (2'(i) < hp) begin
                  grp.res[i].data   = head_r[i];
                  grp.res[i].last   = 1'b0;
                  grp.res[i].status = cxpc_pkg::STAT_SHORT;
                end
              end
              grp.res[hp].data   = b;
              grp.res[hp].last   = 1'b1;
              grp.res[hp].status = cxpc_pkg::STAT_SHORT;
              grp.cnt            = {1'b0, hp} + GRP_CW'(1);
              pos_nxt            = '0;
              past_head_nxt      = 1'b0;
              chain_nxt          = '0;
            end else begin
              pos_nxt = pos_r + 3'd1;
            end
          end else begin
            // fourth head byte: emit the whole head
            grp.cnt           = GRP_CW'(GRP_MAX);
            grp.res[0].data   = r0;
            grp.res[1].data   = r1;
            grp.res[2].data   = r2;
            grp.res[3].data   = r3;
            grp.res[0].last   = 1'b0;
            grp.res[1].last   = 1'b0;
            grp.res[2].last   = 1'b0;
            grp.res[3].last   = item.last_byte;
            for (int i = 0; i < GRP_MAX; i++) begin
              grp.res[i].status = cxpc_pkg::STAT_OK;
            end
            plain_nxt     = enc ? {h3, h2, h1, h0} : {r3, r2, r1, r0};
            chain_nxt     = c3;
            pos_nxt       = 3'd4;
            past_head_nxt = 1'b1;
            do_upd        = item.last_byte;
          end
        end
        default: ;
      endcase
    end

    // end of packet: advance that direction's key
    if (do_upd) begin
      if (enc) begin
        enc_key_nxt = next_key(enc_key_r, plain_nxt);
      end else begin
        dec_key_nxt = next_key(dec_key_r, plain_nxt);
      end
      pos_nxt       = '0;
      past_head_nxt = 1'b0;
      chain_nxt     = '0;
    end
  end

  // control and key state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_key_r   <= '0;
      dec_key_r   <= '0;
      key_vld_r   <= 1'b0;
      pos_r       <= '0;
      past_head_r <= 1'b0;
      chain_r     <= '0;
    end else begin
      enc_key_r   <= enc_key_nxt;
      dec_key_r   <= dec_key_nxt;
      key_vld_r   <= key_vld_nxt;
      pos_r       <= pos_nxt;
      past_head_r <= past_head_nxt;
      chain_r     <= chain_nxt;
    end
  end

  // head buffer and plaintext head, written before read
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      head_r[i] <= head_nxt[i];
    end
    plain_r <= plain_nxt;
  end

endmodule

### rtl/cxpc_outq.sv
// Output queue: takes a group of up to four result words, drains one per cycle while out_ready is high.
module cxpc_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  cxpc_pkg::grp_t     grp,
  output cxpc_pkg::res_t     head,
  output logic               out_valid,
  input  logic               out_ready,
  output cxpc_pkg::qstat_t   qstat
);

  localparam int AW      = cxpc_pkg::Q_AW;
  localparam int CW      = cxpc_pkg::Q_CW;
  localparam int GRP_CWI = cxpc_pkg::GRP_CW;

  cxpc_pkg::res_t  q_r [cxpc_pkg::Q_DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            pop;

  // pointer and fill bookkeeping
  always_comb begin
    pop        = out_valid && out_ready;
    wr_ptr_nxt = wr_ptr_r + AW'(grp.cnt);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    cnt_nxt    = cnt_r + CW'(grp.cnt) - CW'(pop);
  end

  assign out_valid   = (cnt_r != '0);
  assign head        = q_r[rd_ptr_r];
  assign qstat.count = cnt_r;
  assign qstat.room  = (cnt_r <= CW'(cxpc_pkg::Q_DEPTH - cxpc_pkg::GRP_MAX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // group write at consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < cxpc_pkg::GRP_MAX; i++) begin
      if (GRP_CWI'(i) < grp.cnt) begin
        q_r[wr_ptr_r + AW'(i)] <= grp.res[i];
      end
    end
  end

endmodule

### rtl/chained_xor_packet_cipher_top.sv
// Top level of the chained XOR packet cipher.
//
// Input channel (in_valid/in_ready) takes one word per cycle while in_ready is
// high: a seed load (opcode 0), an encrypt byte (1) or a decrypt byte (2);
// opcode 3 is dropped. Result channel (out_valid/out_ready) gives result
// bytes, each with its last flag and status.
// A result passes the input register, then the transform into the output
// queue, before it leaves.
// Throughput: one input word per cycle while in_ready is high. The first three
// bytes of a packet give no result; the fourth gives a burst of four, which
// the eight-word output queue absorbs, so a long stream with a ready receiver
// runs at one byte per cycle. in_ready drops only when the queue holds more
// than four words and the input register is occupied; a stalled receiver
// thus backs up into the input once more than four words are queued, with
// up to eight queued words plus one held word absorbed.
// Reset clears the keys, the key-valid flag, the packet position and the
// queue; bytes arriving before a seed load pass through with status 2.
module chained_xor_packet_cipher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_seed,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [1:0]  out_status
);

  cxpc_pkg::item_t  item_r, item_nxt;
  logic             item_vld_r, item_vld_nxt;
  logic             in_fire, adv;
  cxpc_pkg::grp_t   grp;
  cxpc_pkg::res_t   head;
  cxpc_pkg::qstat_t qstat;

  // input register, released when the queue can take a full group
  always_comb begin
    adv          = item_vld_r && qstat.room;
    in_ready     = !item_vld_r || qstat.room;
    in_fire      = in_valid && in_ready;
    item_vld_nxt = in_fire || (item_vld_r && !adv);
    item_nxt     = item_r;
    if (in_fire) begin
      item_nxt.opcode    = in_opcode;
      item_nxt.data_byte = in_data_byte;
      item_nxt.seed      = in_seed;
      item_nxt.last_byte = in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  cxpc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (item_r),
    .grp   (grp)
  );

  cxpc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp       (grp),
    .head      (head),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .qstat     (qstat)
  );

  assign out_byte   = head.data;
  assign out_last   = head.last;
  assign out_status = head.status;

`ifndef SYNTH
  // queue never fills past its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= cxpc_pkg::Q_CW'(cxpc_pkg::Q_DEPTH))
    else $error("output queue overfilled");

  // a held input word stays put until the queue releases it
  a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && !adv) |=> (item_vld_r && $stable(item_r)))
    else $error("held input word lost or changed");

  // a word can only be pushed when the queue had room
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (grp.cnt != '0) |-> qstat.room)
    else $error("result group pushed without room");

  // reset empties the queue
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");
`endif

endmodule
